// File: rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// shared types and constants of the binary field serializer
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int unsigned OpW           = 3;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned VarintMaxLen  = 10;
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [OpW-1:0] {
    OP_U8     = 3'd0,
    OP_U16    = 3'd1,
    OP_U32    = 3'd2,
    OP_U64    = 3'd3,
    OP_BOOL   = 3'd4,
    OP_VARINT = 3'd5,
    OP_ZIGZAG = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  // one field, ready to be emitted low byte first
  typedef struct packed {
    logic              varint;
    logic [LenW-1:0]   len;
    logic [ValueW-1:0] value;
  } job_t;

endpackage

// File: rtl/bfs_front.sv
// ----------------------------------------------------------------------------
// bfs_front
// classifies one field: zigzag, bool mapping, byte swap for big-endian
// ----------------------------------------------------------------------------
module bfs_front (
  input  logic                         valid_i,
  input  logic [bfs_pkg::OpW-1:0]      op_i,
  input  logic [bfs_pkg::ValueW-1:0]   value_i,
  input  logic                         byte_order_i,
  output logic                         push_o,
  output bfs_pkg::job_t                job_o
);

  bfs_pkg::op_e                op;
  logic [bfs_pkg::ValueW-1:0]  swapped;
  logic [bfs_pkg::LenW-1:0]    nbytes;

  assign op = bfs_pkg::op_e'(op_i);

  always_comb begin
    unique case (op)
      bfs_pkg::OP_U16: nbytes = bfs_pkg::LenW'(2);
      bfs_pkg::OP_U32: nbytes = bfs_pkg::LenW'(4);
      bfs_pkg::OP_U64: nbytes = bfs_pkg::LenW'(8);
      default:         nbytes = bfs_pkg::LenW'(1);
    endcase
  end

  // big-endian: reverse the low nbytes bytes so the back end always sends low byte first
  always_comb begin
    swapped = '0;
    unique case (op)
      bfs_pkg::OP_U16: swapped[15:0] = {value_i[7:0], value_i[15:8]};
      bfs_pkg::OP_U32: begin
        for (int k = 0; k < 4; k++) swapped[8*k +: 8] = value_i[8*(3-k) +: 8];
      end
      bfs_pkg::OP_U64: begin
        for (int k = 0; k < 8; k++) swapped[8*k +: 8] = value_i[8*(7-k) +: 8];
      end
      default: swapped[7:0] = value_i[7:0];
    endcase
  end

  always_comb begin
    job_o.varint = 1'b0;
    job_o.len    = nbytes;
    job_o.value  = byte_order_i ? swapped : value_i;
    unique case (op)
      bfs_pkg::OP_BOOL: begin
        job_o.value = {{(bfs_pkg::ValueW-1){1'b0}}, |value_i};
      end
      bfs_pkg::OP_VARINT: begin
        job_o.varint = 1'b1;
        job_o.len    = bfs_pkg::LenW'(bfs_pkg::VarintMaxLen);
        job_o.value  = value_i;
      end
      bfs_pkg::OP_ZIGZAG: begin
        job_o.varint = 1'b1;
        job_o.len    = bfs_pkg::LenW'(bfs_pkg::VarintMaxLen);
        job_o.value  = {value_i[bfs_pkg::ValueW-2:0], 1'b0}
                     ^ {bfs_pkg::ValueW{value_i[bfs_pkg::ValueW-1]}};
      end
      default: ;
    endcase
  end

  // unused code is taken and dropped
  assign push_o = valid_i && (op != bfs_pkg::OP_NONE);

endmodule

// File: rtl/bfs_fifo.sv
// ----------------------------------------------------------------------------
// bfs_fifo
// short job queue between front and back end
// ----------------------------------------------------------------------------
module bfs_fifo #(
  parameter int unsigned Depth = bfs_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfs_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bfs_pkg::job_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bfs_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/bfs_back.sv
// ----------------------------------------------------------------------------
// bfs_back
// emits the bytes of one job per field, one byte per transfer
// ----------------------------------------------------------------------------
module bfs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  bfs_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [bfs_pkg::ByteW-1:0]  m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  logic                        busy_q, busy_d;
  logic                        varint_q, varint_d;
  logic [bfs_pkg::LenW-1:0]    rem_q, rem_d;
  logic [bfs_pkg::ValueW-1:0]  val_q, val_d;
  logic                        last, take, load;

  assign last = varint_q ? ((val_q[bfs_pkg::ValueW-1:7] == '0) || (rem_q == bfs_pkg::LenW'(1)))
                         : (rem_q == bfs_pkg::LenW'(1));

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = last;
  assign m_axis_tdata_o  = varint_q ? {!last, val_q[6:0]} : val_q[7:0];

  assign take  = busy_q && m_axis_tready_i;
  assign load  = !busy_q || (take && last);
  assign pop_o = load && job_valid_i;

  always_comb begin
    busy_d   = busy_q;
    varint_d = varint_q;
    rem_d    = rem_q;
    val_d    = val_q;
    if (load) begin
      busy_d   = job_valid_i;
      varint_d = job_i.varint;
      rem_d    = job_i.len;
      val_d    = job_i.value;
    end else if (take) begin
      rem_d = rem_q - bfs_pkg::LenW'(1);
      val_d = varint_q ? {7'b0, val_q[bfs_pkg::ValueW-1:7]}
                       : {8'b0, val_q[bfs_pkg::ValueW-1:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    varint_q <= varint_d;
    rem_q    <= rem_d;
    val_q    <= val_d;
  end

endmodule

// File: rtl/binary_field_serializer.sv
// ----------------------------------------------------------------------------
// binary_field_serializer
// serializes one fixed-width, bool or varint field per input transfer
// ----------------------------------------------------------------------------
// Each input transfer carries one field and produces 1 to 10 output byte
// transfers, tlast on the final byte: u8/u16/u32/u64 give 1/2/4/8 bytes in the
// order set by byte_order (0 little-, 1 big-endian), bool gives one byte, and
// varint and zigzag varint give one byte per 7-bit group. The output runs at
// one byte per cycle while m_axis_tready_i is high, from the single byte
// shifter of the back end; consecutive queued fields follow with no gap. A
// queue of QueueDepth classified fields sits between input and output so the
// input keeps taking fields while output stalls, until the queue is full.
// Operation code 7 is taken and yields no bytes. The user must write
// byte_order only while no field is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module binary_field_serializer #(
  parameter int unsigned QueueDepth = bfs_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bfs_pkg::ValueW-1:0]  s_axis_tdata_i,   // value
  input  logic [bfs_pkg::OpW-1:0]     s_axis_tuser_i,   // operation
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bfs_pkg::ByteW-1:0]   m_axis_tdata_o,   // out_byte
  output logic                        m_axis_tlast_o
);

  logic          byte_order_q;
  logic          push, full, job_valid, pop;
  bfs_pkg::job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      byte_order_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !full;

  bfs_front u_front (
    .valid_i      (s_axis_tvalid_i && !full),
    .op_i         (s_axis_tuser_i),
    .value_i      (s_axis_tdata_i),
    .byte_order_i (byte_order_q),
    .push_o       (push),
    .job_o        (job_in)
  );

  bfs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (job_out)
  );

  bfs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_out),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
